// File: hdl/char_lcd_write_sequencer_macros.svh
// Assertion helpers for the sequencer back end.
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define LCDWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdws assertion failed");

// Next-cycle implication, reset-qualified.
`define LCDWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdws assertion failed");

`endif

// File: hdl/lcdws_pkg.sv
package lcdws_pkg;

    localparam int LCDWS_LEN_W   = 16;
    localparam int LCDWS_ADDR_W  = 4;
    localparam int LCDWS_QDEPTH  = 2;   // power of two
    localparam int LCDWS_QPTR_W  = $clog2(LCDWS_QDEPTH);
    localparam int LCDWS_QCNT_W  = $clog2(LCDWS_QDEPTH + 1);

    localparam logic [2:0] LCDWS_LAST8 = 3'd3;
    localparam logic [2:0] LCDWS_LAST4 = 3'd6;
    localparam logic [2:0] LCDWS_HI_PH = 3'd2;
    localparam logic [2:0] LCDWS_LO_PH = 3'd5;

    localparam logic [7:0] LCDWS_MASK_ALL = 8'hFF;
    localparam logic [7:0] LCDWS_MASK_HI  = 8'hF0;
    localparam logic [7:0] LCDWS_MASK_LO  = 8'h0F;
    localparam logic [7:0] LCDWS_SET_DDRAM = 8'h80;

    localparam logic [15:0] LCDWS_LEN_RST = 16'd1000;

    typedef enum logic [1:0] {
        MODE_CMD  = 2'd0,
        MODE_CHAR = 2'd1,
        MODE_MOVE = 2'd2,
        MODE_NONE = 2'd3
    } lcdws_mode_t;

    typedef enum logic [1:0] {
        REG_FOUR_BIT  = 2'd0,
        REG_UPPER     = 2'd1,
        REG_PHASE_LEN = 2'd2,
        REG_SPARE     = 2'd3
    } lcdws_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } lcdws_state_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       rs;
    } lcdws_req_t;

    typedef struct packed {
        logic                   four_bit_bus;
        logic                   upper_pins;
        logic [LCDWS_LEN_W-1:0] phase_len;
    } lcdws_cfg_t;

    function automatic logic [6:0] row_offset(input logic [1:0] row);
        logic [6:0] off;
        case (row)
            2'd0:    off = 7'h00;
            2'd1:    off = 7'h40;
            2'd2:    off = 7'h10;
            default: off = 7'h50;
        endcase
        return off;
    endfunction

endpackage

// File: hdl/lcdws_if.sv
interface lcdws_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] column;

    modport source (output valid, mode, byte_value, row, column, input ready);
    modport sink   (input valid, mode, byte_value, row, column, output ready);
endinterface

interface lcdws_pin_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic [7:0] data_pins;
    logic [7:0] drive_mask;
    logic       last_phase;

    modport source (output valid, reg_select, read_write, enable, data_pins,
                    drive_mask, last_phase, input ready);
    modport sink   (input valid, reg_select, read_write, enable, data_pins,
                    drive_mask, last_phase, output ready);
endinterface

// File: hdl/lcdws_front.sv
module lcdws_front (
    lcdws_req_if.sink         req,
    input  logic              q_full,
    output logic              push,
    output lcdws_pkg::lcdws_req_t push_data
);
    import lcdws_pkg::*;

    lcdws_mode_t mode;
    logic [6:0]  ddram_addr;

    assign mode       = lcdws_mode_t'(req.mode);
    assign ddram_addr = row_offset(req.row) + {1'b0, req.column};

    // Unused mode is taken and dropped.
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full && (mode != MODE_NONE);

    always_comb
    begin
        unique case (mode)
            MODE_CMD:
            begin
                push_data.byte_val = req.byte_value;
                push_data.rs       = 1'b0;
            end
            MODE_CHAR:
            begin
                push_data.byte_val = req.byte_value;
                push_data.rs       = 1'b1;
            end
            MODE_MOVE:
            begin
                push_data.byte_val = LCDWS_SET_DDRAM | {1'b0, ddram_addr};
                push_data.rs       = 1'b0;
            end
            default:
            begin
                push_data.byte_val = req.byte_value;
                push_data.rs       = 1'b0;
            end
        endcase
    end
endmodule

// File: hdl/lcdws_queue.sv
module lcdws_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lcdws_pkg::lcdws_req_t push_data,
    output logic                  full,
    output logic                  q_valid,
    output lcdws_pkg::lcdws_req_t q_data,
    input  logic                  pop
);
    import lcdws_pkg::*;

    lcdws_req_t              mem_reg [LCDWS_QDEPTH];
    logic [LCDWS_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LCDWS_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LCDWS_QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == LCDWS_QCNT_W'(LCDWS_QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end
endmodule

// File: hdl/lcdws_back.sv
module lcdws_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcdws_pkg::lcdws_cfg_t cfg,
    input  logic                  q_valid,
    input  lcdws_pkg::lcdws_req_t q_data,
    output logic                  pop,
    lcdws_pin_if.source           pin
);
    import lcdws_pkg::*;
    `include "char_lcd_write_sequencer_macros.svh"

    lcdws_state_t           state_reg, state_next;
    lcdws_req_t             cur_reg, cur_next;
    logic [2:0]             phase_reg, phase_next;
    logic [LCDWS_LEN_W-1:0] timer_reg, timer_next;
    logic [7:0]             held_reg, held_next;

    logic       out_valid_reg, out_valid_next;
    logic       out_rs_reg;
    logic       out_en_reg;
    logic [7:0] out_data_reg;
    logic [7:0] out_mask_reg;
    logic       out_last_reg;

    logic       issue;
    logic       last;
    logic       en;
    logic [7:0] mask;
    logic [3:0] nib;
    logic [7:0] held_upd;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = ST_RUN;
            ST_RUN:
                if (issue && last && !q_valid)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        issue = (state_reg == ST_RUN) && (timer_reg == '0)
                && (!out_valid_reg || pin.ready);
        last  = cfg.four_bit_bus ? (phase_reg == LCDWS_LAST4)
                                 : (phase_reg == LCDWS_LAST8);
        pop   = q_valid && ((state_reg == ST_IDLE) || (issue && last));

        if (cfg.four_bit_bus)
            en = (phase_reg == 3'd1) || (phase_reg == 3'd2)
                 || (phase_reg == 3'd4) || (phase_reg == 3'd5);
        else
            en = (phase_reg == 3'd1) || (phase_reg == 3'd2);

        if (!cfg.four_bit_bus)
            mask = LCDWS_MASK_ALL;
        else
            mask = cfg.upper_pins ? LCDWS_MASK_HI : LCDWS_MASK_LO;

        nib      = (phase_reg == LCDWS_HI_PH) ? cur_reg.byte_val[7:4]
                                              : cur_reg.byte_val[3:0];
        held_upd = held_reg;
        if (!cfg.four_bit_bus)
        begin
            if (phase_reg == LCDWS_HI_PH)
                held_upd = cur_reg.byte_val;
        end
        else if ((phase_reg == LCDWS_HI_PH) || (phase_reg == LCDWS_LO_PH))
        begin
            held_upd = cfg.upper_pins ? {nib, held_reg[3:0]} : {held_reg[7:4], nib};
        end
    end

    always_comb
    begin
        cur_next   = pop ? q_data : cur_reg;
        phase_next = phase_reg;
        if (pop)
            phase_next = '0;
        else if (issue)
            phase_next = phase_reg + 1'b1;

        timer_next = timer_reg;
        if (issue)
            timer_next = (cfg.phase_len == '0) ? '0 : cfg.phase_len - 1'b1;
        else if (timer_reg != '0)
            timer_next = timer_reg - 1'b1;

        held_next      = issue ? held_upd : held_reg;
        out_valid_next = issue || (out_valid_reg && !pin.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            timer_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (issue)
        begin
            out_rs_reg   <= cur_reg.rs;
            out_en_reg   <= en;
            out_data_reg <= held_upd;
            out_mask_reg <= mask;
            out_last_reg <= last;
        end
    end

    assign pin.valid      = out_valid_reg;
    assign pin.reg_select = out_rs_reg;
    assign pin.read_write = 1'b0;
    assign pin.enable     = out_en_reg;
    assign pin.data_pins  = out_data_reg;
    assign pin.drive_mask = out_mask_reg;
    assign pin.last_phase = out_last_reg;

    `LCDWS_ASSERT_NOW(a_phase_range, clk, rst_n, state_reg == ST_RUN,
        cfg.four_bit_bus ? (phase_reg <= LCDWS_LAST4) : (phase_reg <= LCDWS_LAST8))
    `LCDWS_ASSERT_NEXT(a_mid_stays_run, clk, rst_n, issue && !last,
        state_reg == ST_RUN)
    `LCDWS_ASSERT_NEXT(a_phase_spacing, clk, rst_n, issue && (cfg.phase_len > 16'd1),
        !issue)
endmodule

// File: hdl/char_lcd_write_sequencer.sv
// HD44780 parallel write sequencer.
// req channel: one word per request (mode, byte_value, row, column). Mode 0 sends
//   a command byte, mode 1 a character byte, mode 2 a cursor move (0x80 | row
//   offset + column, 7-bit wrap). Mode 3 is taken and dropped.
// pin channel: one word per pin phase (RS, RW, E, data, drive mask, last flag).
//   An 8-bit transfer gives 4 words, a 4-bit transfer 7 words, high nibble first.
// APB port: four_bit_bus at 0x0, upper_pins at 0x4, phase_len at 0x8; write only
//   while no request is in flight.
// Path: request queue, back-end current register, then the output register.
// Pacing: phase words are paced by the phase timer in the back end, reloaded
//   from phase_len on each word; a request takes 4 or 7 phase words.
//   The front takes one request a cycle while the 2-deep request queue has room,
//   so the next request is already waiting when the current one ends.
// Reset: registers return to 4-bit, upper pins, phase_len 1000; held data pins
//   clear to zero; queue and output register are emptied.
// Stall: a phase word waits in the output register; the back end stops, the
//   queue fills, then req.ready drops.
module char_lcd_write_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    lcdws_req_if.sink                           req,
    lcdws_pin_if.source                         pin,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcdws_pkg::LCDWS_ADDR_W-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import lcdws_pkg::*;

    // configuration registers
    logic                   four_bit_reg, four_bit_next;
    logic                   upper_reg, upper_next;
    logic [LCDWS_LEN_W-1:0] len_reg, len_next;
    logic                   wr_en;
    lcdws_reg_t             reg_idx;
    lcdws_cfg_t             cfg;

    // front to queue to back
    logic       push;
    lcdws_req_t push_data;
    logic       q_full;
    logic       q_valid;
    lcdws_req_t q_data;
    logic       pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = lcdws_reg_t'(paddr[3:2]);

    always_comb
    begin
        four_bit_next = four_bit_reg;
        upper_next    = upper_reg;
        len_next      = len_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_FOUR_BIT:  four_bit_next = pwdata[0];
                REG_UPPER:     upper_next    = pwdata[0];
                REG_PHASE_LEN: len_next      = pwdata[LCDWS_LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FOUR_BIT:  prdata = {31'd0, four_bit_reg};
            REG_UPPER:     prdata = {31'd0, upper_reg};
            REG_PHASE_LEN: prdata = {{(32-LCDWS_LEN_W){1'b0}}, len_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg <= 1'b1;
            upper_reg    <= 1'b1;
            len_reg      <= LCDWS_LEN_RST;
        end
        else
        begin
            four_bit_reg <= four_bit_next;
            upper_reg    <= upper_next;
            len_reg      <= len_next;
        end
    end

    assign cfg.four_bit_bus = four_bit_reg;
    assign cfg.upper_pins   = upper_reg;
    assign cfg.phase_len    = len_reg;

    // classify and build the byte to send
    lcdws_front u_front (
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    lcdws_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    // phase sequencer, timer and held data pins
    lcdws_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .pin     (pin)
    );
endmodule
